>>> src/ismpq_pkg.sv
package ismpq_pkg;

  localparam int unsigned Capacity   = 64;
  localparam int unsigned ElementIds = 256;

  typedef enum logic [1:0] {
    ActInsert = 2'd0,
    ActExtract = 2'd1,
    ActFind = 2'd2,
    ActModify = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    StOk = 3'd0,
    StEmpty = 3'd1,
    StNotFound = 3'd2,
    StFull = 3'd3,
    StDuplicate = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    SIdle,
    SMark,
    SDelete,
    SInsert,
    SShift,
    SDone
  } state_e;

  typedef enum logic [1:0] {
    CellHold,
    CellInsert,
    CellDelete,
    CellShift
  } cell_op_e;

  typedef struct packed {
    logic               valid;
    logic [7:0]         element;
    logic signed [31:0] priority_val;
    logic [31:0]        sequence_val;
  } entry_t;

  typedef struct packed {
    cell_op_e op;
    entry_t   key;
  } cell_cmd_t;

  typedef struct packed {
    action_e            action;
    logic [7:0]         element_id;
    logic signed [31:0] priority_req;
  } req_t;

  typedef struct packed {
    logic [7:0]         out_element;
    logic signed [31:0] out_priority;
    status_e            status;
    logic [6:0]         count;
  } rsp_t;

  // higher priority wins, older sequence breaks ties
  function automatic logic ranks_above(entry_t a, entry_t b);
    logic r;
    if (a.priority_val != b.priority_val) r = a.priority_val > b.priority_val;
    else r = a.sequence_val < b.sequence_val;
    return r;
  endfunction

endpackage

>>> src/ismpq_cell.sv
module ismpq_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ismpq_pkg::cell_cmd_t  cmd_i,
  input  ismpq_pkg::entry_t     left_i,
  input  ismpq_pkg::entry_t     right_i,
  input  logic                  left_above_i,
  output ismpq_pkg::entry_t     entry_o,
  output logic                  above_o,
  output logic                  match_o
);

  ismpq_pkg::entry_t entry_q, entry_d;

  always_comb begin
    above_o = entry_q.valid && ismpq_pkg::ranks_above(entry_q, cmd_i.key);
    match_o = entry_q.valid && (entry_q.element == cmd_i.key.element);
    entry_d = entry_q;
    unique case (cmd_i.op)
      ismpq_pkg::CellHold: entry_d = entry_q;
      // sorted chain: first cell not above the key takes it, the rest shift right
      ismpq_pkg::CellInsert: begin
        if (above_o) entry_d = entry_q;
        else if (left_above_i) entry_d = cmd_i.key;
        else entry_d = left_i;
      end
      ismpq_pkg::CellDelete: begin
        if (above_o) entry_d = entry_q;
        else entry_d = right_i;
      end
      ismpq_pkg::CellShift: entry_d = right_i;
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

>>> src/indexed_stable_max_priority_queue_core.sv
// Flow: find and rejected requests go from idle straight to done; insert passes through the
//   insert state, extract through shift, modify through mark, delete and insert; a result
//   held by out_ready_i stalls the FSM in done. The sorted cell chain does one shift step
//   per cycle and the control FSM serializes items: a new one is taken only when idle.
// Reset: asynchronous active low; queue empty, all ids free, sequence counter zero.
// No clearing pass: cells and id valid bits clear at once.
module indexed_stable_max_priority_queue_core #(
  parameter int unsigned CAPACITY    = ismpq_pkg::Capacity,
  parameter int unsigned ELEMENT_IDS = ismpq_pkg::ElementIds
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ismpq_pkg::req_t  in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ismpq_pkg::rsp_t  out_data_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = (ELEMENT_IDS > 1) ? $clog2(ELEMENT_IDS) : 1;

  ismpq_pkg::state_e    state_q, state_d;
  ismpq_pkg::req_t      req_q;
  ismpq_pkg::status_e   status_q;
  logic [7:0]           res_elem_q;
  logic signed [31:0]   res_pri_q;
  ismpq_pkg::entry_t    key_q;
  logic [CntW-1:0]      count_q;
  logic [31:0]          seq_q;
  logic [ELEMENT_IDS-1:0] valid_q;
  logic                 out_valid_q;
  ismpq_pkg::rsp_t      out_q;

  ismpq_pkg::cell_cmd_t cmd;
  ismpq_pkg::entry_t    ent [CAPACITY];
  logic [CAPACITY-1:0]  above;
  logic [CAPACITY-1:0]  match;
  ismpq_pkg::entry_t    found;

  logic                 in_xfer;
  logic                 id_ok;
  logic                 id_queued;
  logic [IdxW-1:0]      id_idx;
  logic [IdxW-1:0]      root_idx;
  logic                 out_load;
  ismpq_pkg::status_e   status_in;
  logic [7:0]           res_elem_in;
  logic signed [31:0]   res_pri_in;

  assign in_ready_o = (state_q == ismpq_pkg::SIdle);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign id_ok      = {24'd0, in_data_i.element_id} < 32'(ELEMENT_IDS);
  assign id_idx     = IdxW'({24'd0, in_data_i.element_id});
  assign root_idx   = IdxW'({24'd0, ent[0].element});
  assign id_queued  = id_ok && valid_q[id_idx];
  assign out_load   = (state_q == ismpq_pkg::SDone) && (!out_valid_q || out_ready_i);

  always_comb begin
    cmd.key = key_q;
    unique case (state_q)
      ismpq_pkg::SInsert: cmd.op = ismpq_pkg::CellInsert;
      ismpq_pkg::SDelete: cmd.op = ismpq_pkg::CellDelete;
      ismpq_pkg::SShift:  cmd.op = ismpq_pkg::CellShift;
      default:            cmd.op = ismpq_pkg::CellHold;
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ismpq_pkg::entry_t left_e, right_e;
    logic              left_above;
    if (i == 0) begin : g_first
      assign left_e     = '0;
      assign left_above = 1'b1;
    end else begin : g_mid
      assign left_e     = ent[i-1];
      assign left_above = above[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_notlast
      assign right_e = ent[i+1];
    end
    ismpq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .left_i       (left_e),
      .right_i      (right_e),
      .left_above_i (left_above),
      .entry_o      (ent[i]),
      .above_o      (above[i]),
      .match_o      (match[i])
    );
  end

  // at most one cell matches the id being modified
  always_comb begin
    found = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      found = found | (match[i] ? ent[i] : '0);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ismpq_pkg::SIdle: begin
        if (in_xfer) begin
          state_d = ismpq_pkg::SDone;
          unique case (in_data_i.action)
            ismpq_pkg::ActInsert: begin
              if (id_ok && !id_queued && (count_q < CntW'(CAPACITY)))
                state_d = ismpq_pkg::SInsert;
            end
            ismpq_pkg::ActExtract: begin
              if (count_q != '0) state_d = ismpq_pkg::SShift;
            end
            ismpq_pkg::ActFind: state_d = ismpq_pkg::SDone;
            ismpq_pkg::ActModify: begin
              if (id_queued) state_d = ismpq_pkg::SMark;
            end
            default: state_d = ismpq_pkg::SDone;
          endcase
        end
      end
      ismpq_pkg::SMark:   state_d = ismpq_pkg::SDelete;
      ismpq_pkg::SDelete: state_d = ismpq_pkg::SInsert;
      ismpq_pkg::SInsert: state_d = ismpq_pkg::SDone;
      ismpq_pkg::SShift:  state_d = ismpq_pkg::SDone;
      ismpq_pkg::SDone: begin
        if (out_load) state_d = ismpq_pkg::SIdle;
      end
      default: state_d = ismpq_pkg::SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ismpq_pkg::SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      seq_q       <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (in_xfer) begin
        unique case (in_data_i.action)
          ismpq_pkg::ActInsert: begin
            if (id_ok && !id_queued && (count_q < CntW'(CAPACITY))) begin
              valid_q[id_idx] <= 1'b1;
              count_q         <= count_q + 1'b1;
              seq_q           <= seq_q + 32'd1;
            end
          end
          ismpq_pkg::ActExtract: begin
            if (count_q != '0) begin
              valid_q[root_idx] <= 1'b0;
              count_q           <= count_q - 1'b1;
            end
          end
          ismpq_pkg::ActFind: ;
          ismpq_pkg::ActModify: ;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    status_in   = ismpq_pkg::StOk;
    res_elem_in = in_data_i.element_id;
    res_pri_in  = in_data_i.priority_req;
    unique case (in_data_i.action)
      ismpq_pkg::ActInsert: begin
        if (!id_ok) status_in = ismpq_pkg::StNotFound;
        else if (id_queued) status_in = ismpq_pkg::StDuplicate;
        else if (count_q >= CntW'(CAPACITY)) status_in = ismpq_pkg::StFull;
      end
      ismpq_pkg::ActExtract, ismpq_pkg::ActFind: begin
        if (count_q == '0) begin
          status_in   = ismpq_pkg::StEmpty;
          res_elem_in = '0;
          res_pri_in  = '0;
        end else begin
          res_elem_in = ent[0].element;
          res_pri_in  = ent[0].priority_val;
        end
      end
      ismpq_pkg::ActModify: begin
        if (!id_queued) status_in = ismpq_pkg::StNotFound;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_q      <= in_data_i;
      res_elem_q <= res_elem_in;
      res_pri_q  <= res_pri_in;
      key_q      <= {1'b1, in_data_i.element_id, in_data_i.priority_req, seq_q};
      status_q   <= status_in;
    end
    // modify: grab the old key, remove it, then reinsert with the old sequence
    if (state_q == ismpq_pkg::SMark) key_q <= found;
    if (state_q == ismpq_pkg::SDelete) key_q.priority_val <= req_q.priority_req;
    if (out_load) begin
      out_q.out_element  <= res_elem_q;
      out_q.out_priority <= res_pri_q;
      out_q.status       <= status_q;
      out_q.count        <= 7'(count_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("count above capacity");

  a_ids_match_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ismpq_pkg::SIdle) |-> ($countones(valid_q) == int'(count_q)))
    else $error("queued id bits disagree with count");

  a_root_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ismpq_pkg::SIdle) |-> (ent[0].valid == (count_q != '0)))
    else $error("root cell occupancy disagrees with count");

endmodule

>>> tb/indexed_stable_max_priority_queue_core_tb.sv
module indexed_stable_max_priority_queue_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  ismpq_pkg::req_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  ismpq_pkg::rsp_t out_data_o;

  indexed_stable_max_priority_queue_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // heap shadow
  logic [7:0]         heap_elem [ismpq_pkg::Capacity];
  logic signed [31:0] heap_pri  [ismpq_pkg::Capacity];
  logic [31:0]        heap_seq  [ismpq_pkg::Capacity];
  int unsigned        slot_of   [ismpq_pkg::ElementIds];
  bit                 queued    [ismpq_pkg::ElementIds];
  int unsigned        n_queued;
  logic [31:0]        next_seq;

  ismpq_pkg::rsp_t expected_rsp[$];
  bit   idle_en = 1'b1;
  bit   failed = 1'b0;
  int unsigned n_sent, n_checked, cycles;
  int unsigned status_seen [8];

  function automatic bit outranks(int unsigned a, int unsigned b);
    if (heap_pri[a] != heap_pri[b]) return heap_pri[a] > heap_pri[b];
    return heap_seq[a] < heap_seq[b];
  endfunction

  function automatic void swap_slots(int unsigned a, int unsigned b);
    logic [7:0] e;
    logic signed [31:0] p;
    logic [31:0] s;
    e = heap_elem[a]; heap_elem[a] = heap_elem[b]; heap_elem[b] = e;
    p = heap_pri[a];  heap_pri[a]  = heap_pri[b];  heap_pri[b]  = p;
    s = heap_seq[a];  heap_seq[a]  = heap_seq[b];  heap_seq[b]  = s;
    slot_of[heap_elem[a]] = a;
    slot_of[heap_elem[b]] = b;
  endfunction

  function automatic void sift_up(int unsigned i);
    int unsigned up;
    while (i > 0) begin
      up = (i - 1) / 2;
      if (!outranks(i, up)) break;
      swap_slots(i, up);
      i = up;
    end
  endfunction

  function automatic void sift_down(int unsigned i);
    int unsigned l, r, best;
    forever begin
      l = 2 * i + 1;
      r = 2 * i + 2;
      best = i;
      if (l < n_queued && outranks(l, best)) best = l;
      if (r < n_queued && outranks(r, best)) best = r;
      if (best == i) break;
      swap_slots(i, best);
      i = best;
    end
  endfunction

  function automatic ismpq_pkg::rsp_t serve_request(ismpq_pkg::req_t rq);
    ismpq_pkg::rsp_t rs;
    int unsigned s;
    logic signed [31:0] old;
    rs.out_element  = rq.element_id;
    rs.out_priority = rq.priority_req;
    rs.status       = ismpq_pkg::StOk;
    case (rq.action)
      ismpq_pkg::ActInsert: begin
        if (queued[rq.element_id]) rs.status = ismpq_pkg::StDuplicate;
        else if (n_queued >= ismpq_pkg::Capacity) rs.status = ismpq_pkg::StFull;
        else begin
          s = n_queued;
          heap_elem[s] = rq.element_id;
          heap_pri[s]  = rq.priority_req;
          heap_seq[s]  = next_seq;
          next_seq++;
          queued[rq.element_id] = 1'b1;
          slot_of[rq.element_id] = s;
          n_queued = s + 1;
          sift_up(s);
        end
      end
      ismpq_pkg::ActExtract, ismpq_pkg::ActFind: begin
        if (n_queued == 0) begin
          rs.status = ismpq_pkg::StEmpty;
          rs.out_element = '0;
          rs.out_priority = '0;
        end else begin
          rs.out_element = heap_elem[0];
          rs.out_priority = heap_pri[0];
          if (rq.action == ismpq_pkg::ActExtract) begin
            queued[heap_elem[0]] = 1'b0;
            n_queued--;
            if (n_queued > 0) begin
              heap_elem[0] = heap_elem[n_queued];
              heap_pri[0]  = heap_pri[n_queued];
              heap_seq[0]  = heap_seq[n_queued];
              slot_of[heap_elem[0]] = 0;
              sift_down(0);
            end
          end
        end
      end
      default: begin
        if (!queued[rq.element_id]) rs.status = ismpq_pkg::StNotFound;
        else begin
          s = slot_of[rq.element_id];
          old = heap_pri[s];
          heap_pri[s] = rq.priority_req;
          if (rq.priority_req > old) sift_up(s);
          else sift_down(s);
        end
      end
    endcase
    rs.count = n_queued[6:0];
    return rs;
  endfunction

  task automatic send_req(ismpq_pkg::action_e act, logic [7:0] id, logic signed [31:0] pri);
    ismpq_pkg::req_t rq;
    int unsigned gap;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rq.action = act;
    rq.element_id = id;
    rq.priority_req = pri;
    in_valid_i <= 1'b1;
    in_data_i <= rq;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_rsp.push_back(serve_request(rq));
    n_sent++;
  endtask

  always begin
    @(posedge clk_i);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      out_ready_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    out_ready_i <= 1'b1;
  end

  always @(posedge clk_i) begin
    ismpq_pkg::rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_rsp.size() == 0) begin
        $display("%0t unexpected result %p", $time, out_data_o);
        failed = 1'b1;
      end else begin
        want = expected_rsp.pop_front();
        n_checked++;
        status_seen[want.status]++;
        if (out_data_o.out_element !== want.out_element) begin
          $display("%0t out_element exp %0d got %0d", $time, want.out_element,
                   out_data_o.out_element);
          failed = 1'b1;
        end
        if (out_data_o.out_priority !== want.out_priority) begin
          $display("%0t out_priority exp %0d got %0d", $time, want.out_priority,
                   out_data_o.out_priority);
          failed = 1'b1;
        end
        if (out_data_o.status !== want.status) begin
          $display("%0t status exp %0d got %0d", $time, want.status, out_data_o.status);
          failed = 1'b1;
        end
        if (out_data_o.count !== want.count) begin
          $display("%0t count exp %0d got %0d", $time, want.count, out_data_o.count);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic signed [31:0] pick_priority();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'sh7fffffff - $urandom_range(0, 2);
      2: return 32'sh80000000 + $urandom_range(0, 2);
      default: return $signed($urandom_range(0, 8)) - 4;
    endcase
  endfunction

  function automatic logic [7:0] pick_queued_id();
    if (n_queued == 0) return 8'($urandom);
    return heap_elem[$urandom_range(0, n_queued - 1)];
  endfunction

  task automatic drain();
    while (n_queued > 0) send_req(ismpq_pkg::ActExtract, 8'd0, 32'sd0);
  endtask

  task automatic test_empty_queue();
    send_req(ismpq_pkg::ActExtract, 8'd0, 32'sd0);
    send_req(ismpq_pkg::ActFind, 8'hff, -32'sd1);
    send_req(ismpq_pkg::ActModify, 8'd9, 32'sd5);
  endtask

  task automatic test_extremes_and_ties();
    send_req(ismpq_pkg::ActInsert, 8'd0, 32'sh80000000);
    send_req(ismpq_pkg::ActInsert, 8'hff, 32'sh7fffffff);
    send_req(ismpq_pkg::ActInsert, 8'h55, 32'sd7);
    send_req(ismpq_pkg::ActInsert, 8'haa, 32'sd7);
    send_req(ismpq_pkg::ActInsert, 8'h0f, 32'sd7);
    send_req(ismpq_pkg::ActInsert, 8'h55, 32'sd1);          // duplicate
    send_req(ismpq_pkg::ActFind, 8'd0, 32'sd0);
    send_req(ismpq_pkg::ActModify, 8'h0f, 32'sd100);        // rises
    send_req(ismpq_pkg::ActModify, 8'hff, -32'sd50);        // falls
    send_req(ismpq_pkg::ActModify, 8'haa, 32'sd7);          // unchanged
    send_req(ismpq_pkg::ActModify, 8'h33, 32'sd7);          // not queued
    send_req(ismpq_pkg::ActModify, 8'd0, 32'sh7fffffff);    // lowest jumps to the top
    drain();
  endtask

  task automatic test_fill_to_full();
    for (int i = 0; i < ismpq_pkg::Capacity; i++)
      send_req(ismpq_pkg::ActInsert, i[7:0] ^ 8'ha5, pick_priority());
    send_req(ismpq_pkg::ActInsert, 8'h12, 32'sd0);
    send_req(ismpq_pkg::ActInsert, 8'ha5, 32'sd0);
    for (int i = 0; i < 8; i++)
      send_req(ismpq_pkg::ActModify, pick_queued_id(), pick_priority());
    drain();
  endtask

  task automatic test_random_mix(int unsigned n);
    int unsigned r;
    for (int unsigned k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (k > n - 200) idle_en = 1'b0;
      if (r < 40)
        send_req(ismpq_pkg::ActInsert,
                 $urandom_range(0, 3) == 0 ? pick_queued_id() : 8'($urandom),
                 pick_priority());
      else if (r < 62) send_req(ismpq_pkg::ActExtract, 8'($urandom), $urandom);
      else if (r < 72) send_req(ismpq_pkg::ActFind, 8'($urandom), $urandom);
      else if (r < 92) send_req(ismpq_pkg::ActModify, pick_queued_id(), pick_priority());
      else send_req(ismpq_pkg::action_e'($urandom_range(0, 3)), 8'($urandom), $urandom);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_queue();
    test_extremes_and_ties();
    test_fill_to_full();
    test_random_mix(1000);
    drain();
    in_valid_i <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("sent %0d requests, checked %0d results", n_sent, n_checked);
    $display("ok %0d empty %0d notfound %0d full %0d dup %0d",
             status_seen[ismpq_pkg::StOk], status_seen[ismpq_pkg::StEmpty],
             status_seen[ismpq_pkg::StNotFound], status_seen[ismpq_pkg::StFull],
             status_seen[ismpq_pkg::StDuplicate]);
    if (!failed) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    n_queued = 0;
    next_seq = '0;
    n_sent = 0;
    n_checked = 0;
    cycles = 0;
    foreach (queued[i]) queued[i] = 1'b0;
    foreach (slot_of[i]) slot_of[i] = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
  end
endmodule
